// ----- rtl/fvls_pkg.sv -----
package fvls_pkg;

  localparam int PAGE_WORDS = 4096;
  localparam int MEM_WORDS  = 2 * PAGE_WORDS;
  localparam int SLOT_AW    = $clog2(PAGE_WORDS);
  localparam int MEM_AW     = $clog2(MEM_WORDS);

  localparam logic [15:0] ST_ERASED    = 16'hFFFF;
  localparam logic [15:0] ST_RECEIVING = 16'hEEEE;
  localparam logic [15:0] ST_VALID     = 16'h0000;
  localparam logic [31:0] SLOT_BLANK   = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_BOTH,
    ACT_PAGE0,
    ACT_PAGE1
  } init_act_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WIPE,
    S_SCAN,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic capture;
    logic wipe_start;
    logic wipe_step;
    logic scan_start;
    logic scan_step;
    logic res_load;
    logic res_scan;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    init_act_t  act;
    logic       sweep_last;
    logic       hit;
    logic       miss;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ----- rtl/flash_variable_log_store_top.sv -----
// Emulated EEPROM held in two flash pages of PAGE_WORDS 32-bit slots each, kept in one
// on-chip memory of 2*PAGE_WORDS words with one read and one write port. After reset the
// block runs a clearing pass over all 2*PAGE_WORDS slots that sets every slot to ones,
// and accepts no word until it ends. Items are then taken one at a time: a read scans the
// active page one slot per cycle from the top down to slot 1, a write scans from slot 1
// upward for the first blank slot, and an init erases one page or both, as the page
// status words call for. A finished result waits in the output register while the next
// word is taken.
module flash_variable_log_store_top import fvls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // virt_addr, write_data
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data
  output logic [1:0]  m_tuser    // status
);

  cmd_t     cmd;
  dp_stat_t stat;

  fvls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fvls_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ----- rtl/fvls_ctrl.sv -----
module fvls_ctrl import fvls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_INIT: begin
            state_next = (stat.act == ACT_NONE) ? S_FINISH : S_WIPE;
          end
          KIND_READ, KIND_WRITE: begin
            state_next = S_SCAN;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_WIPE: begin
        if (stat.sweep_last) state_next = S_FINISH;
      end
      S_SCAN: begin
        if (stat.hit || stat.miss) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.wipe_step = 1'b1;
      end
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_INIT: begin
            if (stat.act == ACT_NONE) begin
              cmd.res_load = 1'b1;
            end else begin
              cmd.wipe_start = 1'b1;
            end
          end
          KIND_READ, KIND_WRITE: begin
            cmd.scan_start = 1'b1;
          end
          default: begin
            cmd.res_load = 1'b1;
          end
        endcase
      end
      S_WIPE: begin
        cmd.wipe_step = 1'b1;
        cmd.res_load  = stat.sweep_last;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.res_load  = stat.hit || stat.miss;
        cmd.res_scan  = 1'b1;
      end
      S_FINISH: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/fvls_dpath.sv -----
module fvls_dpath import fvls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  input  cmd_t        cmd,
  output dp_stat_t    stat
);

  logic [1:0]  kind;
  logic [15:0] vaddr;
  logic [15:0] wdata;
  logic [15:0] page_status [2];

  logic [MEM_AW-1:0]  sw;
  logic [MEM_AW-1:0]  sw_end;
  logic               page;
  logic [SLOT_AW-1:0] idx;
  logic [SLOT_AW-1:0] chk_idx;
  logic               chk_vld;
  logic               chk_last;
  logic               issue_done;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rdata;

  logic [15:0] res_data;
  logic [1:0]  res_stat;

  init_act_t         act;
  logic              is_read;
  logic              is_write;
  logic              hit;
  logic              miss;
  logic              issue_last;
  logic              rd_en;
  logic              wr_en;
  logic [MEM_AW-1:0] base;
  logic [MEM_AW-1:0] rd_addr;
  logic [MEM_AW-1:0] wr_addr;
  logic [31:0]       wr_word;

  always_comb begin
    if (page_status[0] == ST_ERASED && page_status[1] == ST_ERASED) begin
      act = ACT_BOTH;
    end else if (page_status[0] == ST_RECEIVING && page_status[1] == ST_VALID) begin
      act = ACT_PAGE0;
    end else if (page_status[0] == ST_VALID && page_status[1] == ST_RECEIVING) begin
      act = ACT_PAGE1;
    end else begin
      act = ACT_NONE;
    end
  end

  assign is_read    = (kind == KIND_READ);
  assign is_write   = (kind == KIND_WRITE);
  assign hit        = chk_vld && (is_write ? (rdata == SLOT_BLANK) : (rdata[31:16] == vaddr));
  assign miss       = chk_vld && chk_last && !hit;
  assign issue_last = is_write ? (idx == SLOT_AW'(PAGE_WORDS - 1)) : (idx == SLOT_AW'(1));

  assign base    = page ? MEM_AW'(PAGE_WORDS) : '0;
  assign rd_en   = cmd.scan_step && !issue_done;
  assign rd_addr = base + MEM_AW'(idx);
  assign wr_en   = cmd.wipe_step || (cmd.scan_step && is_write && hit);
  assign wr_addr = cmd.wipe_step ? sw : (base + MEM_AW'(chk_idx));
  assign wr_word = cmd.wipe_step ? SLOT_BLANK : {vaddr, wdata};

  assign stat.kind       = kind;
  assign stat.act        = act;
  assign stat.sweep_last = (sw == sw_end);
  assign stat.hit        = hit;
  assign stat.miss       = miss;
  assign stat.out_busy   = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw             <= '0;
      sw_end         <= MEM_AW'(MEM_WORDS - 1);
      page_status[0] <= ST_ERASED;
      page_status[1] <= ST_ERASED;
      chk_vld        <= 1'b0;
      issue_done     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cmd.wipe_start) begin
        case (act)
          ACT_BOTH: begin
            sw             <= '0;
            sw_end         <= MEM_AW'(MEM_WORDS - 1);
            page_status[0] <= ST_VALID;
            page_status[1] <= ST_ERASED;
          end
          ACT_PAGE0: begin
            sw             <= '0;
            sw_end         <= MEM_AW'(PAGE_WORDS - 1);
            page_status[0] <= ST_ERASED;
            page_status[1] <= ST_VALID;
          end
          ACT_PAGE1: begin
            sw             <= MEM_AW'(PAGE_WORDS);
            sw_end         <= MEM_AW'(MEM_WORDS - 1);
            page_status[0] <= ST_VALID;
            page_status[1] <= ST_ERASED;
          end
          default: begin
            sw <= sw;
          end
        endcase
      end else if (cmd.wipe_step) begin
        sw <= sw + MEM_AW'(1);
      end

      if (cmd.scan_start) begin
        chk_vld    <= 1'b0;
        issue_done <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_vld <= !issue_done;
        if (!issue_done && issue_last) issue_done <= 1'b1;
      end

      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind  <= s_tuser;
      vaddr <= s_tdata[15:0];
      wdata <= s_tdata[31:16];
    end
    if (cmd.scan_start) begin
      page <= (page_status[1] == ST_VALID);
      idx  <= is_write ? SLOT_AW'(1) : SLOT_AW'(PAGE_WORDS - 1);
    end else if (rd_en) begin
      idx      <= is_write ? (idx + SLOT_AW'(1)) : (idx - SLOT_AW'(1));
      chk_idx  <= idx;
      chk_last <= issue_last;
    end
    if (cmd.res_load) begin
      res_data <= (cmd.res_scan && is_read && hit) ? rdata[15:0] : 16'h0000;
      if (cmd.res_scan && miss) begin
        res_stat <= is_write ? STAT_FULL : STAT_MISS;
      end else begin
        res_stat <= STAT_OK;
      end
    end
    if (cmd.out_load) begin
      m_tdata <= res_data;
      m_tuser <= res_stat;
    end
  end

endmodule

// ----- rtl/fvls_checker.sv -----
module fvls_checker import fvls_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // one word in flight: no back-to-back accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STAT_OK |-> m_tdata == 16'h0000)
    else $error("failed result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_MISS || m_tuser == STAT_FULL))
    else $error("unknown status code");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind flash_variable_log_store_top fvls_checker u_fvls_checker (.*);
